FILE: src/gst_pkg.sv
// ============================================================================
// gst_pkg: shared constants for the 2-D five-point / nine-point stencil unit
// Sizes of the line store, sample and counters, register indexes and modes.
// ============================================================================
`default_nettype none

package gst_pkg;

    // Line store depth: longest supported grid row
    localparam int LINE_MAX       = 4096;
    localparam int ADDR_BITS      = $clog2(LINE_MAX);

    // Sample format and the growth of the nine-point weighted sum (weights total 16)
    localparam int SAMPLE_BITS    = 32;
    localparam int SUM_BITS       = SAMPLE_BITS + 4;

    // Fixed field and register widths
    localparam int WIDTH_BITS     = 13;
    localparam int HEIGHT_BITS    = 16;
    localparam int POINT_COL_BITS = 12;
    localparam int ROW_BITS       = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Register reset values and the smallest grid dimension
    localparam int WIDTH_RESET    = 4096;
    localparam int HEIGHT_RESET   = 4096;
    localparam int MIN_DIM        = 3;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STENCIL_MODE = 2'd2;

    // Stencil modes
    localparam logic MODE_FIVE_POINT = 1'b0;
    localparam logic MODE_NINE_POINT = 1'b1;

endpackage : gst_pkg

`default_nettype wire

FILE: src/grid_stencil_5pt_9pt_unit.sv
// ============================================================================
// grid_stencil_5pt_9pt_unit: streaming 2-D Jacobi stencil, five or nine point
// Counts raster position, keeps the two previous rows in a line store and a
// 3x3 window, and emits the updated value of every interior grid point.
// ============================================================================
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_sample
//  m_        out        m_valid/m_ready    m_new_value, m_point_col,
//                                          m_point_row, m_frame_last
//  cfg_      in         cfg_we             cfg_index, cfg_data
//
//  One sample per clock while the output is not stalled: the line store takes one
//  read and one write-back a cycle, always at different columns. A sample
//  transfer loads the compute stage, which computes and writes back when it
//  completes; m_valid is registered behind the compute stage. Reset (aresetn,
//  synchronous) clears counters, window and registers, not the line store. A
//  stalled output holds the compute stage and, behind it, s_ready.
//
`default_nettype none

module grid_stencil_5pt_9pt_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [gst_pkg::SAMPLE_BITS-1:0] s_sample,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [gst_pkg::SAMPLE_BITS-1:0]     m_new_value,
    output logic [gst_pkg::POINT_COL_BITS-1:0]         m_point_col,
    output logic [gst_pkg::ROW_BITS-1:0]               m_point_row,
    output logic                                       m_frame_last,

    input  wire logic                                  cfg_we,
    input  wire logic [gst_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [gst_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int AB = gst_pkg::ADDR_BITS;
    localparam int SB = gst_pkg::SAMPLE_BITS;
    localparam int UB = gst_pkg::SUM_BITS;
    localparam int RB = gst_pkg::ROW_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [gst_pkg::WIDTH_BITS-1:0]  grid_width_reg;
    logic [gst_pkg::HEIGHT_BITS-1:0] grid_height_reg;
    logic                            stencil_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg   <= gst_pkg::WIDTH_BITS'(gst_pkg::WIDTH_RESET);
            grid_height_reg  <= gst_pkg::HEIGHT_BITS'(gst_pkg::HEIGHT_RESET);
            stencil_mode_reg <= gst_pkg::MODE_FIVE_POINT;
        end else if (cfg_we) begin
            case (cfg_index)
                gst_pkg::REG_GRID_WIDTH:   grid_width_reg   <= cfg_data[gst_pkg::WIDTH_BITS-1:0];
                gst_pkg::REG_GRID_HEIGHT:  grid_height_reg  <= cfg_data[gst_pkg::HEIGHT_BITS-1:0];
                gst_pkg::REG_STENCIL_MODE: stencil_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Last column and row after clamping the registers into range
    logic [31:0]   gw_ext;
    logic [31:0]   gh_ext;
    logic [AB-1:0] last_col;
    logic [RB-1:0] last_row;

    always_comb begin
        gw_ext = 32'(grid_width_reg);
        gh_ext = 32'(grid_height_reg);
        if (gw_ext < 32'(gst_pkg::MIN_DIM)) begin
            last_col = AB'(gst_pkg::MIN_DIM - 1);
        end else if (gw_ext > 32'(gst_pkg::LINE_MAX)) begin
            last_col = AB'(gst_pkg::LINE_MAX - 1);
        end else begin
            last_col = AB'(gw_ext - 32'd1);
        end
        if (gh_ext < 32'(gst_pkg::MIN_DIM)) begin
            last_row = RB'(gst_pkg::MIN_DIM - 1);
        end else begin
            last_row = RB'(gh_ext - 32'd1);
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic s_fire;
    logic m_valid_reg;
    logic c_valid_reg;     // compute stage holds an item
    logic c_emit_reg;
    logic c_go;            // compute stage completes this cycle

    assign c_go    = c_valid_reg && (!c_emit_reg || !m_valid_reg || m_ready);
    assign s_ready = !c_valid_reg || c_go;
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Position counters, advanced at the input transfer
    // ------------------------------------------------------------------
    logic [AB-1:0] col_count_reg, col_count_next;
    logic [RB-1:0] row_count_reg, row_count_next;
    logic          at_last_col;
    logic          at_last_row;

    assign at_last_col = col_count_reg >= last_col;
    assign at_last_row = row_count_reg >= last_row;

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (s_fire) begin
            if (at_last_col) begin
                col_count_next = '0;
                row_count_next = at_last_row ? '0 : row_count_reg + RB'(1);
            end else begin
                col_count_next = col_count_reg + AB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage registers
    // ------------------------------------------------------------------
    logic signed [SB-1:0] c_sample_reg;
    logic [AB-1:0]        c_col_reg;
    logic [RB-1:0]        c_row_reg;
    logic                 c_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            c_emit_reg  <= 1'b0;
        end else if (s_fire) begin
            c_valid_reg <= 1'b1;
            c_emit_reg  <= (col_count_reg >= AB'(2)) && (row_count_reg >= RB'(2));
        end else if (c_go) begin
            c_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            c_sample_reg <= s_sample;
            c_col_reg    <= col_count_reg;
            c_row_reg    <= row_count_reg;
            c_last_reg   <= at_last_col && at_last_row;
        end
    end

    // ------------------------------------------------------------------
    // Line store: one entry per column, {older row, newer row}
    // Read at the input transfer, written back when the compute stage completes.
    // Consecutive items always hit different columns, so the two never collide.
    // ------------------------------------------------------------------
    logic [2*SB-1:0] line_mem [gst_pkg::LINE_MAX];
    logic [2*SB-1:0] rd_data_reg;
    logic signed [SB-1:0] top;
    logic signed [SB-1:0] mid;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= line_mem[col_count_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (c_go) begin
            line_mem[c_col_reg] <= {mid, c_sample_reg};
        end
    end

    assign top = rd_data_reg[2*SB-1:SB];
    assign mid = rd_data_reg[SB-1:0];

    // ------------------------------------------------------------------
    // 3x3 window: columns x-2 (win0..2) and x-1 (win3..5), top to bottom
    // ------------------------------------------------------------------
    logic signed [SB-1:0] win_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (c_go) begin
            // shift left one column, load the new one
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= c_sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stencil arithmetic
    // ------------------------------------------------------------------
    logic signed [UB-1:0] edge_sum;
    logic signed [UB-1:0] corner_sum;
    logic signed [UB-1:0] nine_sum;
    logic signed [UB-1:0] shifted;
    logic signed [SB-1:0] result;

    always_comb begin
        edge_sum   = UB'(win_reg[3]) + UB'(win_reg[5]) + UB'(win_reg[1]) + UB'(mid);
        corner_sum = UB'(win_reg[0]) + UB'(win_reg[2]) + UB'(top) + UB'(c_sample_reg);
        nine_sum   = (UB'(win_reg[4]) <<< 2) + (edge_sum <<< 1) + corner_sum;
        if (stencil_mode_reg == gst_pkg::MODE_NINE_POINT) begin
            shifted = nine_sum >>> 4;
        end else begin
            shifted = edge_sum >>> 2;
        end
        result = shifted[SB-1:0];
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic signed [SB-1:0]               out_value_reg;
    logic [gst_pkg::POINT_COL_BITS-1:0] out_col_reg;
    logic [RB-1:0]                      out_row_reg;
    logic                               out_last_reg;
    logic [AB-1:0]                      c_col_m1;

    assign c_col_m1 = c_col_reg - AB'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (c_go && c_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_go && c_emit_reg) begin
            out_value_reg <= result;
            out_col_reg   <= gst_pkg::POINT_COL_BITS'(c_col_m1);
            out_row_reg   <= c_row_reg - RB'(1);
            out_last_reg  <= c_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_new_value  = out_value_reg;
    assign m_point_col  = out_col_reg;
    assign m_point_row  = out_row_reg;
    assign m_frame_last = out_last_reg;

`ifndef ASSERT_OFF
    // Boundary points never produce a result
    a_interior_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_col_reg != '0 && out_row_reg != '0))
        else $error("result for a boundary point");

    // A held compute stage keeps its item and the line store data under it
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && !c_go) |=> (c_valid_reg && $stable(c_col_reg)
                                    && $stable(rd_data_reg)))
        else $error("compute stage lost its item while stalled");

    // Column counter wraps after the last column
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && at_last_col) |=> (col_count_reg == '0))
        else $error("column counter failed to wrap");

    // Completing an item that emits never overwrites a waiting result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_go && c_emit_reg) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");
`endif

endmodule : grid_stencil_5pt_9pt_unit

`default_nettype wire
